/* hw/rtl/kab_pkg.sv */
package kab_pkg;

  // Port word and field widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;
  localparam int KEY_W       = 16;
  localparam int LIMIT_W     = 7;
  localparam int COUNT_W     = 6;

  // Operation codes
  localparam logic [1:0] OP_SAVE  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_LIMIT = 2'd3;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SAVE2 = 3'b010,
    S_LOAD  = 3'b100
  } state_t;

endpackage

/* hw/rtl/kab_byte_ram.sv */
module kab_byte_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, hold data when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/keyed_append_buffer_table.sv */
// Keyed append buffer table. SLOTS slots, each tagged by the low KEY_BITS bits of a
// 16-bit key, hold an append-only byte buffer of BUFFER_BYTES-1 usable bytes. Slot
// tags, use flags and lengths sit in registers; the buffer bytes sit in one
// synchronous byte RAM with one write and one read port. A save byte is written
// as it is accepted, except the first byte of a message into a non-empty, non-full
// buffer, which is held and written from S_SAVE2 because the newline separator
// and the byte share the single write port. A load reads its bytes through the
// registered RAM read port and gives one byte per cycle while the output is
// taken; an empty or failed load, a clear and an unused operation finish in
// S_IDLE. The byte RAM needs no clearing after reset; the block is ready as soon as
// reset is released. Results sit in an output register; a new word is taken only
// while that register is empty or its result is taken in the same cycle.
module keyed_append_buffer_table #(
  parameter int SLOTS        = 8,
  parameter int BUFFER_BYTES = 64,
  parameter int KEY_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // key[15:0], data_byte[23:16], read_limit[30:24], zero [31]
  input  logic [kab_pkg::IN_TDATA_W-1:0]       in_tdata,
  // operation[1:0], first[2]
  input  logic [kab_pkg::IN_TUSER_W-1:0]       in_tuser,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // status[1:0], count[7:2], out_byte[15:8]
  output logic [kab_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // byte_valid[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW        = $clog2(BUFFER_BYTES);
  localparam int AW        = SW + LW;
  localparam int MEM_DEPTH = SLOTS * (1 << LW);
  localparam int KW        = (KEY_BITS < kab_pkg::KEY_W) ? KEY_BITS : kab_pkg::KEY_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(BUFFER_BYTES - 1);

  // Input word fields
  logic [KW-1:0]                in_key;
  logic [7:0]                   in_byte;
  logic [kab_pkg::LIMIT_W-1:0]  in_limit;
  logic [1:0]                   in_op;
  logic                         in_first;
  logic                         in_acc;

  assign in_key   = in_tdata[KW-1:0];
  assign in_byte  = in_tdata[23:16];
  assign in_limit = in_tdata[30:24];
  assign in_op    = in_tuser[1:0];
  assign in_first = in_tuser[2];

  // Slot table and session state
  logic              slot_used_r [SLOTS];
  logic [KW-1:0]     slot_key_r  [SLOTS];
  logic [LW-1:0]     slot_len_r  [SLOTS];
  logic              slot_used_nxt [SLOTS];
  logic [KW-1:0]     slot_key_nxt  [SLOTS];
  logic [LW-1:0]     slot_len_nxt  [SLOTS];
  logic [SW-1:0]     active_r, active_nxt;
  logic              failed_r, failed_nxt;
  logic [LW-1:0]     save_cnt_r, save_cnt_nxt;

  kab_pkg::state_t   state_r, state_nxt;
  logic [7:0]        held_byte_r, held_byte_nxt;
  logic              held_last_r, held_last_nxt;

  // Load sequencer
  logic [SW-1:0]     load_slot_r, load_slot_nxt;
  logic [LW-1:0]     load_n_r, load_n_nxt;
  logic [LW-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic [LW-1:0]     emit_cnt_r, emit_cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [kab_pkg::COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [7:0]                   out_byte_r, out_byte_nxt;
  logic                         out_bv_r, out_bv_nxt;
  logic                         out_eor_r, out_eor_nxt;
  logic                         out_free;
  logic                         emit;

  // Byte RAM ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Key lookup and free slot search
  logic          hit;
  logic [SW-1:0] hit_idx;
  logic          free_any;
  logic [SW-1:0] free_idx;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == kab_pkg::S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Find matching slot and lowest free slot, lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used_r[i] && (slot_key_r[i] == in_key)) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!slot_used_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // Main read-modify-write logic
  always_comb begin
    logic          app_go;
    logic [7:0]    app_byte;
    logic          app_last;
    logic [SW-1:0] s;
    logic [LW-1:0] len_cur;
    logic [LW-1:0] app_len;
    logic [kab_pkg::LIMIT_W-1:0] lim_m1;
    logic [LW-1:0] n;

    app_go   = 1'b0;
    app_byte = in_byte;
    app_last = in_tlast;
    s        = '0;
    len_cur  = '0;
    app_len  = '0;
    lim_m1   = in_limit - kab_pkg::LIMIT_W'(1);
    n        = '0;

    for (int i = 0; i < SLOTS; i++) begin
      slot_used_nxt[i] = slot_used_r[i];
      slot_key_nxt[i]  = slot_key_r[i];
      slot_len_nxt[i]  = slot_len_r[i];
    end
    active_nxt    = active_r;
    failed_nxt    = failed_r;
    save_cnt_nxt  = save_cnt_r;
    state_nxt     = state_r;
    held_byte_nxt = held_byte_r;
    held_last_nxt = held_last_r;
    load_slot_nxt = load_slot_r;
    load_n_nxt    = load_n_r;
    issue_cnt_nxt = issue_cnt_r;
    emit_cnt_nxt  = emit_cnt_r;
    rd_pend_nxt   = rd_pend_r;

    emit           = 1'b0;
    out_status_nxt = kab_pkg::ST_OK;
    out_cnt_nxt    = '0;
    out_byte_nxt   = '0;
    out_bv_nxt     = 1'b0;
    out_eor_nxt    = 1'b1;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = {load_slot_r, issue_cnt_r};

    case (state_r)
      kab_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            kab_pkg::OP_SAVE: begin
              app_go = 1'b1;
              // Open a session: find or claim a slot
              if (in_first) begin
                save_cnt_nxt = '0;
                if (hit) begin
                  s       = hit_idx;
                  len_cur = slot_len_r[hit_idx];
                end else if (free_any) begin
                  s                = free_idx;
                  slot_used_nxt[s] = 1'b1;
                  slot_key_nxt[s]  = in_key;
                  len_cur          = '0;
                end
                if (!hit && !free_any) begin
                  failed_nxt = 1'b1;
                end else begin
                  failed_nxt = 1'b0;
                  active_nxt = s;
                  if (len_cur >= LEN_MAX) begin
                    slot_len_nxt[s] = '0;
                  end else if (len_cur != '0) begin
                    // Write separator now, defer the byte to S_SAVE2
                    mem_we          = 1'b1;
                    mem_waddr       = {s, len_cur};
                    mem_wdata       = kab_pkg::NEWLINE;
                    slot_len_nxt[s] = len_cur + LW'(1);
                    held_byte_nxt   = in_byte;
                    held_last_nxt   = in_tlast;
                    state_nxt       = kab_pkg::S_SAVE2;
                    app_go          = 1'b0;
                  end else begin
                    slot_len_nxt[s] = '0;
                  end
                end
              end
            end
            kab_pkg::OP_LOAD: begin
              emit = 1'b1;
              if (in_limit == '0) begin
                out_status_nxt = kab_pkg::ST_BAD_LIMIT;
              end else begin
                if (hit) begin
                  n = slot_len_r[hit_idx];
                  if (kab_pkg::LIMIT_W'(n) > lim_m1) begin
                    n = lim_m1[LW-1:0];
                  end
                end
                if (n != '0) begin
                  // Start the read sequence
                  emit          = 1'b0;
                  load_slot_nxt = hit_idx;
                  load_n_nxt    = n;
                  issue_cnt_nxt = '0;
                  emit_cnt_nxt  = '0;
                  rd_pend_nxt   = 1'b0;
                  state_nxt     = kab_pkg::S_LOAD;
                end
              end
            end
            kab_pkg::OP_CLEAR: begin
              emit = 1'b1;
              if (hit) begin
                slot_used_nxt[hit_idx] = 1'b0;
                slot_len_nxt[hit_idx]  = '0;
              end else begin
                out_status_nxt = kab_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end

      kab_pkg::S_SAVE2: begin
        app_byte = held_byte_r;
        app_last = held_last_r;
        if (!held_last_r || out_free) begin
          app_go    = 1'b1;
          state_nxt = kab_pkg::S_IDLE;
        end
      end

      kab_pkg::S_LOAD: begin
        // Move a fetched byte to the output
        if (rd_pend_r && out_free) begin
          emit         = 1'b1;
          out_cnt_nxt  = kab_pkg::COUNT_W'(load_n_r);
          out_byte_nxt = mem_rdata;
          out_bv_nxt   = 1'b1;
          out_eor_nxt  = (emit_cnt_r == load_n_r - LW'(1));
          emit_cnt_nxt = emit_cnt_r + LW'(1);
          rd_pend_nxt  = 1'b0;
          if (out_eor_nxt) begin
            state_nxt = kab_pkg::S_IDLE;
          end
        end
        // Fetch the next byte when its slot in the output is assured
        if ((issue_cnt_r != load_n_r) && (!rd_pend_r || out_free)) begin
          mem_re        = 1'b1;
          issue_cnt_nxt = issue_cnt_r + LW'(1);
          rd_pend_nxt   = 1'b1;
        end
      end

      default: begin
        state_nxt = kab_pkg::S_IDLE;
      end
    endcase

    // Append one content byte to the session slot
    if (app_go) begin
      if (!failed_nxt) begin
        app_len = slot_len_nxt[active_nxt];
        if (app_len < LEN_MAX) begin
          mem_we                   = 1'b1;
          mem_waddr                = {active_nxt, app_len};
          mem_wdata                = app_byte;
          slot_len_nxt[active_nxt] = app_len + LW'(1);
          save_cnt_nxt             = save_cnt_nxt + LW'(1);
        end
      end
      if (app_last) begin
        emit = 1'b1;
        if (failed_nxt) begin
          out_status_nxt = kab_pkg::ST_NO_SLOT;
        end else begin
          out_cnt_nxt = kab_pkg::COUNT_W'(save_cnt_nxt);
        end
      end
    end

    // Output register: load a new word or drop the taken one
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used_r[i] <= 1'b0;
        slot_key_r[i]  <= '0;
        slot_len_r[i]  <= '0;
      end
      active_r    <= '0;
      failed_r    <= 1'b0;
      save_cnt_r  <= '0;
      state_r     <= kab_pkg::S_IDLE;
      issue_cnt_r <= '0;
      emit_cnt_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used_r[i] <= slot_used_nxt[i];
        slot_key_r[i]  <= slot_key_nxt[i];
        slot_len_r[i]  <= slot_len_nxt[i];
      end
      active_r    <= active_nxt;
      failed_r    <= failed_nxt;
      save_cnt_r  <= save_cnt_nxt;
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
    held_last_r <= held_last_nxt;
    load_slot_r <= load_slot_nxt;
    load_n_r    <= load_n_nxt;
    if (emit) begin
      out_status_r <= out_status_nxt;
      out_cnt_r    <= out_cnt_nxt;
      out_byte_r   <= out_byte_nxt;
      out_bv_r     <= out_bv_nxt;
      out_eor_r    <= out_eor_nxt;
    end
  end

  kab_byte_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_byte_r, out_cnt_r, out_status_r};
  assign out_tuser  = out_bv_r;
  assign out_tlast  = out_eor_r;

  // Loads never write the byte RAM
  a_load_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kab_pkg::S_LOAD) |-> !mem_we)
    else $error("byte RAM written during load");

  // A pending read exists only inside a load
  a_pend_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == kab_pkg::S_LOAD))
    else $error("read pending outside load");

  // The final loaded byte ends the load
  a_load_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == kab_pkg::S_LOAD) && emit && out_eor_nxt) |=> (state_r == kab_pkg::S_IDLE))
    else $error("load did not end after final byte");

  // Session slot never exceeds its usable size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_len_r[active_r] <= LEN_MAX)
    else $error("slot length out of range");

endmodule
